// File: src/lbs_pkg.sv
// Shared types, constants and action codes for the literal binding store.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;
    localparam int StoreSize  = 1024;
    localparam int TrailDepth = 1024;
    localparam int NumVars    = 1024;
    localparam int AW = 10;
    localparam int LW = 11;

    typedef enum logic [2:0] {
        ACT_NEW = 3'd0, ACT_BIND = 3'd1, ACT_MARK = 3'd2, ACT_UNDO = 3'd3, ACT_QUERY = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_LIT = 3'd1, ST_BOUND = 3'd2, ST_LOOKUP = 3'd3,
        ST_FULL = 3'd4, ST_LIMIT = 3'd5
    } t_status;

    // memory port request from sequencer
    typedef struct packed {
        logic          val_we;
        logic          cls_we;
        logic [AW-1:0] waddr;
        logic [LW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_BIND_RD, S_BIND_CHK, S_WALK_RD, S_WALK_STEP,
        S_BIND_WR1, S_BIND_WR2, S_UNDO_RD, S_UNDO_WR, S_Q_RD, S_Q_CHK,
        S_Q_NEXT, S_OUT
    } t_state;
endpackage
`default_nettype wire

// File: src/lbs_stores.sv
// Value and class stores: one write port and one registered read port each.
`timescale 1ns / 1ps
`default_nettype none
module lbs_stores import lbs_pkg::*; (
    input  wire logic          i_clk,
    input  wire t_mem_req      i_req,
    output logic [LW-1:0]      o_val_rd,
    output logic [LW-1:0]      o_cls_rd
);
    logic [LW-1:0] r_val_mem [StoreSize];
    logic [LW-1:0] r_cls_mem [StoreSize];

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) r_val_mem[i_req.waddr] <= i_req.wdata;
        if (i_req.cls_we) r_cls_mem[i_req.waddr] <= i_req.wdata;
        o_val_rd <= r_val_mem[i_req.raddr];
        o_cls_rd <= r_cls_mem[i_req.raddr];
    end
endmodule
`default_nettype wire

// File: src/lbs_trail.sv
// Undo trail memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lbs_trail import lbs_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic [22:0]     i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output logic [22:0]          o_rdata
);
    logic [22:0] r_mem [TrailDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/literal_binding_store_with_undo.sv
// Top level: sequencer over the value, class and trail memories.
// Bind reads the value entry of x, then walks the class chain of y; undo pops trail words
// down to a marked word; query walks up to four chains (value and class of x, class of y).
// One word in work at a time; the next is taken only once the result has been loaded for output.
// Reset: synchronous active low; entries 0 and 1 of both stores read as constants,
// other entries are written on allocation, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module literal_binding_store_with_undo import lbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_action,
    input  wire logic signed [10:0] i_x,
    input  wire logic signed [10:0] i_y,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic signed [10:0]      o_literal_out,
    output logic signed [10:0]      o_value_literal,
    output logic signed [10:0]      o_class_literal,
    output logic                    o_literal_flag,
    output logic [1:0]              o_bound_state,
    output logic signed [10:0]      o_next_in_class,
    output logic [1:0]              o_same_class,
    output logic [9:0]              o_variable_count
);
    t_state r_state, n_state;
    t_mem_req s_req;
    logic [LW-1:0] s_val_rd, s_cls_rd;
    logic [22:0] s_tr_rd;
    logic s_tr_we;
    logic [AW-1:0] s_tr_waddr, s_tr_raddr;
    logic [22:0] s_tr_wdata;

    logic [2:0] r_act, n_act;
    logic signed [LW-1:0] r_x, n_x, r_y, n_y;
    logic [LW-1:0] r_top, n_top;
    logic [LW-1:0] r_nv, n_nv;
    logic r_mark, n_mark;
    // walk engine
    logic signed [LW-1:0] r_cur, n_cur, r_wres, n_wres;
    logic [LW-1:0] r_steps, n_steps;
    logic r_wsel, n_wsel;      // 1 value store, 0 class store
    logic r_limit, n_limit;
    logic [1:0] r_walk, n_walk; // query walk index
    logic [1:0] r_bidx, n_bidx;
    logic signed [LW-1:0] r_bx, n_bx, r_by, n_by, r_yc, n_yc;
    logic r_oval, n_oval;
    logic [2:0] r_st, n_st;
    logic signed [LW-1:0] r_lo, n_lo, r_vl, n_vl, r_cl, n_cl, r_nx, n_nx, r_a, n_a;
    logic r_fl, n_fl;
    logic [1:0] r_bs, n_bs, r_sc, n_sc;
    // result word held for the output side
    logic [2:0] r_ost;
    logic signed [LW-1:0] r_olo, r_ovl, r_ocl, r_onx;
    logic r_ofl;
    logic [1:0] r_obs, r_osc;
    logic [AW-1:0] r_ocnt;

    lbs_stores u_stores (.i_clk(i_clk), .i_req(s_req), .o_val_rd(s_val_rd),
        .o_cls_rd(s_cls_rd));
    lbs_trail u_trail (.i_clk(i_clk), .i_we(s_tr_we), .i_waddr(s_tr_waddr),
        .i_wdata(s_tr_wdata), .i_raddr(s_tr_raddr), .o_rdata(s_tr_rd));

    function automatic logic is_lit(logic signed [LW-1:0] v, logic [LW-1:0] nv);
        logic [LW-1:0] a;
        a = v[LW-1] ? LW'(-v) : v;
        return (v != LW'(1)) && (v != -LW'(1)) && (v != '0) && (a < nv);
    endfunction

    function automatic logic signed [LW-1:0] absv(logic signed [LW-1:0] v);
        return v[LW-1] ? -v : v;
    endfunction

    // entries 0 and 1 are constant; others come from memory
    logic [LW-1:0] s_ridx;
    logic signed [LW-1:0] s_map;
    logic signed [LW-1:0] s_link;
    assign s_ridx = LW'(absv(r_cur));
    always_comb begin
        if (s_ridx == '0)           s_map = '0;
        else if (s_ridx == LW'(1))  s_map = LW'(1);
        else                        s_map = r_wsel ? s_val_rd : s_cls_rd;
        s_link = r_cur[LW-1] ? -s_map : s_map;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_oval;
    assign o_status = r_ost;
    assign o_literal_out = r_olo;
    assign o_value_literal = r_ovl;
    assign o_class_literal = r_ocl;
    assign o_literal_flag = r_ofl;
    assign o_bound_state = r_obs;
    assign o_next_in_class = r_onx;
    assign o_same_class = r_osc;
    assign o_variable_count = r_ocnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top <= '0;
            r_nv <= LW'(2);
            r_mark <= 1'b1;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top <= n_top;
            r_nv <= n_nv;
            r_mark <= n_mark;
            r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_x <= n_x; r_y <= n_y;
        r_cur <= n_cur; r_wres <= n_wres; r_steps <= n_steps; r_wsel <= n_wsel;
        r_limit <= n_limit; r_walk <= n_walk; r_bidx <= n_bidx;
        r_bx <= n_bx; r_by <= n_by; r_yc <= n_yc;
        r_st <= n_st; r_lo <= n_lo; r_vl <= n_vl; r_cl <= n_cl; r_nx <= n_nx;
        r_a <= n_a; r_fl <= n_fl; r_bs <= n_bs; r_sc <= n_sc;
    end

    // load the finished word when the output side is free
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_oval || i_ready)) begin
            r_ost <= r_st; r_olo <= r_lo; r_ovl <= r_vl; r_ocl <= r_cl;
            r_ofl <= r_fl; r_obs <= r_bs; r_onx <= r_nx; r_osc <= r_sc;
            r_ocnt <= AW'(r_nv - LW'(2));
        end
    end

    always_comb begin
        logic walk_done;
        logic signed [LW-1:0] wr;
        logic [LW-1:0] ax;
        n_state = r_state;
        n_act = r_act; n_x = r_x; n_y = r_y; n_top = r_top; n_nv = r_nv;
        n_mark = r_mark; n_cur = r_cur; n_wres = r_wres; n_steps = r_steps;
        n_wsel = r_wsel; n_limit = r_limit; n_walk = r_walk; n_bidx = r_bidx;
        n_bx = r_bx; n_by = r_by; n_yc = r_yc; n_oval = r_oval;
        n_st = r_st; n_lo = r_lo; n_vl = r_vl; n_cl = r_cl; n_nx = r_nx; n_a = r_a;
        n_fl = r_fl; n_bs = r_bs; n_sc = r_sc;
        s_req = '0;
        s_req.raddr = s_ridx[AW-1:0];
        s_tr_we = 1'b0;
        s_tr_waddr = r_top[AW-1:0];
        s_tr_wdata = '0;
        s_tr_raddr = AW'(r_top - LW'(1));
        walk_done = 1'b0;
        wr = '0;
        ax = LW'(absv(r_x));
        if (r_oval && i_ready) n_oval = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act = i_action; n_x = i_x; n_y = i_y;
                    n_st = ST_OK; n_lo = '0; n_vl = '0; n_cl = '0; n_nx = '0;
                    n_fl = 1'b0; n_bs = '0; n_sc = '0; n_limit = 1'b0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_act)
                    ACT_NEW: begin
                        if (r_nv >= LW'(StoreSize)) n_st = ST_FULL;
                        else begin
                            s_req.val_we = 1'b1; s_req.cls_we = 1'b1;
                            s_req.waddr = r_nv[AW-1:0]; s_req.wdata = '0;
                            n_lo = r_nv;
                            n_nv = r_nv + LW'(1);
                        end
                        n_state = S_OUT;
                    end
                    ACT_BIND: begin
                        if (!is_lit(r_x, r_nv)) begin
                            n_st = ST_NOT_LIT; n_state = S_OUT;
                        end else begin
                            n_bx = absv(r_x);
                            n_by = r_x[LW-1] ? -r_y : r_y;
                            n_cur = absv(r_x); n_wsel = 1'b1;
                            n_state = S_BIND_RD;
                        end
                    end
                    ACT_MARK: begin
                        n_mark = 1'b1; n_state = S_OUT;
                    end
                    ACT_UNDO: n_state = (r_top == '0) ? S_OUT : S_UNDO_RD;
                    ACT_QUERY: begin
                        n_fl = is_lit(r_x, r_nv);
                        if (ax < LW'(2) || ax >= r_nv) n_bs = 2'd2;
                        n_cur = ax; n_wsel = 1'b1;
                        n_state = S_Q_RD;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            // read value entry of bx (address driven from r_cur)
            S_BIND_RD: n_state = S_BIND_CHK;
            S_BIND_CHK: begin
                if (s_val_rd != '0) begin
                    n_st = ST_BOUND; n_state = S_OUT;
                end else begin
                    n_cur = r_by; n_wsel = 1'b0; n_steps = '0; n_bidx = 2'd0;
                    n_walk = 2'd0;
                    n_state = S_WALK_RD;
                end
            end
            S_Q_RD: n_state = S_Q_CHK;
            S_Q_CHK: begin
                if (n_bs != 2'd2 && r_bs != 2'd2) n_bs = (s_val_rd != '0) ? 2'd1 : 2'd0;
                if (!r_x[LW-1] && r_x > 1 && $unsigned(r_x) < r_nv) n_nx = s_cls_rd;
                n_bidx = 2'd1;
                n_steps = '0;
                if (r_x == LW'(1) || r_x == -LW'(1)) begin
                    n_vl = r_x; n_cl = r_x;
                    n_walk = 2'd2; n_cur = r_x; n_wsel = 1'b0;
                end else if (r_fl) begin
                    n_walk = 2'd0; n_cur = r_x; n_wsel = 1'b1;
                end else begin
                    n_walk = 2'd2; n_cur = r_x; n_wsel = 1'b0;
                end
                n_state = S_WALK_RD;
            end
            // one walk step: test current, issue read
            S_WALK_RD: begin
                if (r_cur == '0) begin
                    walk_done = 1'b1; wr = r_wres;
                end else if (r_steps >= LW'(NumVars > 2047 ? 2047 : NumVars)
                             && NumVars <= 2047) begin
                    walk_done = 1'b1; wr = '0; n_limit = 1'b1;
                end else if (r_cur == LW'(1) || r_cur == -LW'(1)) begin
                    walk_done = 1'b1; wr = r_cur;
                end else if (s_ridx >= LW'(StoreSize)) begin
                    walk_done = 1'b1; wr = '0;
                end else begin
                    n_steps = r_steps + LW'(1);
                    n_wres = r_cur;
                    n_state = S_WALK_STEP;
                end
                if (r_steps == '0 && r_cur == '0) wr = r_cur;
                if (walk_done) n_state = S_Q_NEXT;
            end
            S_WALK_STEP: begin
                n_cur = s_link;
                n_state = S_WALK_RD;
            end
            // pass on to output; walk results are routed where the walk ends
            S_Q_NEXT: begin
                // nothing is recomputed: results were routed by the dispatch from S_WALK_RD
                n_state = S_OUT;
            end
            S_BIND_WR1: begin
                s_tr_we = 1'b1;
                s_tr_wdata = {r_mark, 1'b1, r_bx[AW-1:0], 11'd0};
                s_req.val_we = 1'b1; s_req.waddr = r_bx[AW-1:0]; s_req.wdata = r_by;
                n_top = r_top + LW'(1);
                n_mark = 1'b0;
                n_lo = r_y;
                n_state = (r_yc == LW'(1) || r_yc == -LW'(1)) ? S_OUT : S_BIND_WR2;
                n_cur = absv(r_yc); n_wsel = 1'b0;
            end
            // class entry of c was read during WR1 via r_yc address
            S_BIND_WR2: begin
                s_tr_we = 1'b1;
                s_tr_wdata = {1'b0, 1'b0, r_cur[AW-1:0], s_cls_rd};
                s_req.cls_we = 1'b1; s_req.waddr = r_cur[AW-1:0];
                s_req.wdata = r_yc[LW-1] ? -r_bx : r_bx;
                n_top = r_top + LW'(1);
                n_state = S_OUT;
            end
            S_UNDO_RD: n_state = S_UNDO_WR;
            S_UNDO_WR: begin
                s_tr_raddr = AW'(r_top - LW'(1));
                s_req.waddr = s_tr_rd[AW+10:11];
                s_req.wdata = s_tr_rd[10:0];
                s_req.val_we = s_tr_rd[21];
                s_req.cls_we = !s_tr_rd[21];
                n_top = r_top - LW'(1);
                if (s_tr_rd[22] || r_top == LW'(1)) n_state = S_OUT;
                else n_state = S_UNDO_RD;
            end
            S_OUT: begin
                if (!r_oval || i_ready) begin
                    n_oval = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // dispatch of finished walk (decided in S_WALK_RD)
        if (walk_done) begin
            if (r_act == ACT_BIND) begin
                if (wr == '0) begin
                    n_st = n_limit ? ST_LIMIT : ST_LOOKUP; n_state = S_OUT;
                end else begin
                    n_yc = wr;
                    if (LW'(TrailDepth) - r_top
                        < ((wr == LW'(1) || wr == -LW'(1)) ? LW'(1) : LW'(2))) begin
                        n_st = ST_FULL; n_state = S_OUT;
                    end else begin
                        s_req.raddr = AW'(absv(wr));
                        n_state = S_BIND_WR1;
                    end
                end
            end else begin
                n_steps = '0; n_wres = '0;
                unique case (r_walk)
                    2'd0: begin
                        n_vl = wr; n_walk = 2'd1; n_cur = r_x; n_wsel = 1'b0;
                        n_state = S_WALK_RD;
                    end
                    2'd1: begin
                        n_cl = wr; n_walk = 2'd2; n_cur = r_x; n_wsel = 1'b0;
                        n_state = S_WALK_RD;
                    end
                    2'd2: begin
                        n_a = wr;
                        if (wr == '0) begin
                            n_sc = 2'd2; n_state = S_OUT;
                            n_st = n_limit ? ST_LIMIT : ST_OK;
                        end else begin
                            n_walk = 2'd3; n_cur = r_y; n_wsel = 1'b0;
                            n_state = S_WALK_RD;
                        end
                    end
                    default: begin
                        n_sc = (wr == '0) ? 2'd2 : ((wr == r_a) ? 2'd1 : 2'd0);
                        n_st = n_limit ? ST_LIMIT : ST_OK;
                        n_state = S_OUT;
                    end
                endcase
            end
        end
        if (r_state == S_BIND_WR1) s_req.raddr = AW'(absv(r_yc));
        if (r_state == S_UNDO_RD || r_state == S_UNDO_WR)
            s_tr_raddr = AW'(r_top - LW'(1));
        if (r_state == S_DISPATCH && r_act == ACT_BIND) s_req.raddr = AW'(absv(r_x));
        if (r_state == S_DISPATCH && r_act == ACT_QUERY) s_req.raddr = ax[AW-1:0];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> !o_ready)
        else $error("accepted word did not start work");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_valid && !i_ready) |=> r_state == S_OUT)
        else $error("result overwritten while output stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nv >= LW'(2) && r_nv <= LW'(StoreSize))
        else $error("allocation counter out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= LW'(TrailDepth))
        else $error("trail overflow");
endmodule
`default_nettype wire

// File: tb/sv/tb_literal_binding_store_with_undo.sv
// Testbench for the literal binding store: directed and random actions against a predictor.
`timescale 1ns / 1ps
module tb_literal_binding_store_with_undo import lbs_pkg::*; ();

    localparam logic [2:0] ActUnknown = 3'd7;
    localparam int IdleLimit = 60000;

    typedef struct {
        logic [2:0]  status;
        logic [10:0] lit;
        logic [10:0] val;
        logic [10:0] cls;
        logic        flag;
        logic [1:0]  bound;
        logic [10:0] nxt;
        logic [1:0]  same;
        logic [9:0]  count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [2:0] i_action = '0;
    logic signed [10:0] i_x = '0;
    logic signed [10:0] i_y = '0;
    logic o_ready, o_valid, o_literal_flag;
    logic [2:0] o_status;
    logic signed [10:0] o_literal_out, o_value_literal, o_class_literal, o_next_in_class;
    logic [1:0] o_bound_state, o_same_class;
    logic [9:0] o_variable_count;

    literal_binding_store_with_undo i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int vals [StoreSize];
    int links [StoreSize];
    bit tr_marked [TrailDepth];
    bit tr_isval [TrailDepth];
    int tr_index [TrailDepth];
    int tr_old [TrailDepth];
    int tr_top;
    int next_var;
    bit mark_flag;

    t_answer pending_answers[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    function automatic int chain_end(int x, bit on_value, inout bit hit);
        int last;
        int steps;
        int e;
        last = x;
        steps = 0;
        while (x != 0) begin
            if (steps >= NumVars) begin
                hit = 1'b1;
                return 0;
            end
            steps++;
            last = x;
            if (last < 0) begin
                if (last == -1) return -1;
                if (-last >= StoreSize) return 0;
                e = on_value ? vals[-last] : links[-last];
                x = -e;
            end else begin
                if (last == 1) return 1;
                if (last >= StoreSize) return 0;
                x = on_value ? vals[last] : links[last];
            end
        end
        return last;
    endfunction

    function automatic bit is_var(int x);
        return (x > 1 && x < next_var) || (x < -1 && -x < next_var);
    endfunction

    function automatic void trail_push(bit isval, int idx, int old);
        int slot;
        slot = tr_top % TrailDepth;
        tr_marked[slot] = mark_flag;
        tr_isval[slot] = isval;
        tr_index[slot] = idx;
        tr_old[slot] = old;
        tr_top++;
        mark_flag = 1'b0;
    endfunction

    function automatic t_answer apply_action(logic [2:0] act, int x, int y);
        t_answer r;
        bit hit;
        int bx, by, yc, need, c, a, b, ax, slot;
        r = '{default: '0};
        hit = 1'b0;
        case (act)
            ACT_NEW: begin
                if (next_var >= StoreSize) begin
                    r.status = ST_FULL;
                end else begin
                    vals[next_var] = 0;
                    links[next_var] = 0;
                    r.lit = 11'(next_var);
                    next_var++;
                end
            end
            ACT_BIND: begin
                bx = x;
                by = y;
                if (!is_var(x)) begin
                    r.status = ST_NOT_LIT;
                end else begin
                    if (bx < 0) begin
                        bx = -bx;
                        by = -by;
                    end
                    if (vals[bx] != 0) begin
                        r.status = ST_BOUND;
                    end else begin
                        yc = chain_end(by, 1'b0, hit);
                        if (yc == 0) begin
                            r.status = hit ? ST_LIMIT : ST_LOOKUP;
                        end else begin
                            need = (yc == 1 || yc == -1) ? 1 : 2;
                            if (TrailDepth - tr_top < need) begin
                                r.status = ST_FULL;
                            end else begin
                                trail_push(1'b1, bx, vals[bx]);
                                vals[bx] = by;
                                if (need == 2) begin
                                    c = yc < 0 ? -yc : yc;
                                    if (c < StoreSize) begin
                                        trail_push(1'b0, c, links[c]);
                                        links[c] = yc < 0 ? -bx : bx;
                                    end
                                end
                                r.lit = 11'(y);
                            end
                        end
                    end
                end
            end
            ACT_MARK: mark_flag = 1'b1;
            ACT_UNDO: begin
                while (tr_top > 0) begin
                    slot = (tr_top - 1) % TrailDepth;
                    tr_top--;
                    if (tr_index[slot] >= 0 && tr_index[slot] < StoreSize) begin
                        if (tr_isval[slot]) vals[tr_index[slot]] = tr_old[slot];
                        else links[tr_index[slot]] = tr_old[slot];
                    end
                    if (tr_marked[slot]) break;
                end
            end
            ACT_QUERY: begin
                r.flag = is_var(x);
                if (x == 1 || x == -1) begin
                    r.val = 11'(x);
                    r.cls = 11'(x);
                end else if (r.flag) begin
                    r.val = 11'(chain_end(x, 1'b1, hit));
                    r.cls = 11'(chain_end(x, 1'b0, hit));
                end
                ax = x < 0 ? -x : x;
                if (ax < 2 || ax >= next_var) r.bound = 2'd2;
                else r.bound = (vals[ax] != 0) ? 2'd1 : 2'd0;
                if (x > 1 && x < next_var) r.nxt = 11'(links[x]);
                a = chain_end(x, 1'b0, hit);
                b = (a != 0) ? chain_end(y, 1'b0, hit) : 0;
                if (a == 0 || b == 0) r.same = 2'd2;
                else r.same = (a == b) ? 2'd1 : 2'd0;
                r.status = hit ? ST_LIMIT : ST_OK;
            end
            default: ;
        endcase
        r.count = 10'(next_var - 2);
        return r;
    endfunction

    // one word per call; predict at the accepting edge
    task automatic send_word(logic [2:0] act, int x, int y);
        if (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_x <= 11'(x);
        i_y <= 11'(y);
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        pending_answers.push_back(apply_action(act, x, y));
        words_in++;
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // a literal whose chains only touch allocated entries
    function automatic int pick_literal();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 0;
        if (r < 14) return $urandom_range(1) ? 1 : -1;
        if (next_var <= 2) return 1;
        r = $urandom_range(next_var - 1, 2);
        return $urandom_range(1) ? r : -r;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    always @(negedge i_clk) begin
        t_answer e;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t watchdog: no handshake in %0d cycles", $time, IdleLimit);
                $display("status: fail");
                $finish;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            words_out++;
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected result word, status %0d", $time, o_status);
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if ({o_status, o_literal_out, o_value_literal, o_class_literal, o_literal_flag,
                     o_bound_state, o_next_in_class, o_same_class, o_variable_count} !==
                    {e.status, e.lit, e.val, e.cls, e.flag, e.bound, e.nxt, e.same, e.count})
                begin
                    errors++;
                    $display("%0t mismatch exp st=%0d lit=%0d val=%0d cls=%0d flg=%0d",
                             $time, e.status, $signed(e.lit), $signed(e.val),
                             $signed(e.cls), e.flag);
                    $display("%0t          exp bnd=%0d nxt=%0d same=%0d cnt=%0d",
                             $time, e.bound, $signed(e.nxt), e.same, e.count);
                    $display("%0t          got st=%0d lit=%0d val=%0d cls=%0d flg=%0d",
                             $time, o_status, o_literal_out, o_value_literal,
                             o_class_literal, o_literal_flag);
                    $display("%0t          got bnd=%0d nxt=%0d same=%0d cnt=%0d",
                             $time, o_bound_state, o_next_in_class, o_same_class,
                             o_variable_count);
                end
            end
        end
    end

    task automatic test_constants();
        send_word(ACT_QUERY, 1, -1);
        send_word(ACT_QUERY, -1, -1);
        send_word(ACT_QUERY, 0, 1);
        send_word(ACT_UNDO, 0, 0);
        send_word(ACT_BIND, 1, 1);
        send_word(ACT_BIND, -1023, 0);
        send_word(ACT_NEW, 0, 0);
        send_word(ActUnknown, -1, -1);
    endtask

    task automatic test_bind_and_undo();
        send_word(ACT_NEW, 0, 0);
        send_word(ACT_NEW, 0, 0);
        send_word(ACT_NEW, 0, 0);
        send_word(ACT_BIND, 2, 0);
        send_word(ACT_MARK, 0, 0);
        send_word(ACT_BIND, -2, 3);
        send_word(ACT_BIND, 2, 4);
        send_word(ACT_BIND, 4, -1);
        send_word(ACT_QUERY, 2, 4);
        send_word(ACT_QUERY, -3, 2);
        send_word(ACT_UNDO, 0, 0);
        send_word(ACT_QUERY, 2, 3);
        send_word(ACT_UNDO, 0, 0);
    endtask

    // two binds that close a loop on both chains, driving walks to the step limit
    task automatic test_walk_limit();
        send_word(ACT_MARK, 0, 0);
        send_word(ACT_BIND, 2, 3);
        send_word(ACT_BIND, 3, 2);
        send_word(ACT_QUERY, 2, 3);
        send_word(ACT_BIND, 4, 2);
        send_word(ACT_UNDO, 0, 0);
    endtask

    task automatic random_actions(int n);
        int r, x;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_word(ACT_NEW, $urandom_range(2047) - 1024, $urandom_range(2047) - 1024);
            end else if (r < 52) begin
                x = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) - 1024 : pick_literal();
                send_word(ACT_BIND, x, pick_literal());
            end else if (r < 62) begin
                send_word(ACT_MARK, 0, 0);
            end else if (r < 72) begin
                send_word(ACT_UNDO, 0, 0);
            end else if (r < 98) begin
                send_word(ACT_QUERY, pick_literal(), pick_literal());
            end else begin
                send_word(3'($urandom_range(7, 5)), pick_literal(), pick_literal());
            end
        end
    endtask

    task automatic test_fill_store();
        while (next_var < StoreSize) send_word(ACT_NEW, 0, 0);
        send_word(ACT_NEW, 0, 0);
        send_word(ACT_QUERY, 1023, -1023);
        send_word(ACT_BIND, -1023, 1022);
    endtask

    initial begin
        foreach (vals[k]) begin
            vals[k] = 0;
            links[k] = 0;
        end
        vals[1] = 1;
        links[1] = 1;
        tr_top = 0;
        next_var = 2;
        mark_flag = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_constants();
        test_bind_and_undo();
        test_walk_limit();
        random_actions(150);
        calm = 1'b1;
        random_actions(100);
        calm = 1'b0;
        test_fill_store();
        random_actions(130);
        go_quiet();
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d action words, %0d results: alloc to full, binds, marks,",
                 words_in, words_out);
        $display("undo, queries, walk loops and trail unwinding, %0d mismatches", errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
